@@ hw/rtl/pitc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pitc_pkg
// Shared widths, constants, control word types and the microcode program of
// the PI temperature controller.
// ----------------------------------------------------------------------------
package pitc_pkg;

   localparam int unsigned ADC_BITS_DEFAULT = 10;

   localparam int unsigned SAMPLE_W   = 10;
   localparam int unsigned TEMP_W     = 17;
   localparam int unsigned GAIN_W     = 16;
   localparam int unsigned DRIVE_W    = 8;
   localparam int unsigned INTEG_W    = 24;
   localparam int unsigned ERR_W      = 18;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 17;
   localparam int unsigned STEP_W     = 4;
   localparam int unsigned MB_W       = 18;
   localparam int unsigned SUM_W      = 36;

   localparam logic [INTEG_W-1:0] LIMIT_Q16 = 24'hFF0000;
   localparam logic [INTEG_W:0]   LIMIT_X2  = 25'h1FE0000;

   localparam logic [TEMP_W-1:0] SETPOINT_RST   = 17'd7168;
   localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd12800;
   localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd2560;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SETPOINT   = 2'd0,
      CSR_PROP_GAIN  = 2'd1,
      CSR_INTEG_GAIN = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_LOAD,
      OP_MUL,
      OP_QUOT,
      OP_FIX,
      OP_ERR,
      OP_INTEG,
      OP_DRIVE
   } op_type;

   typedef enum logic [1:0] {
      MUL_RECIP,
      MUL_INTEG,
      MUL_PROP
   } mul_sel_type;

   typedef enum logic [1:0] {
      HOLD_NONE,
      HOLD_IN,
      HOLD_OUT
   } hold_type;

   typedef struct packed {
      op_type      op;
      mul_sel_type mul;
      hold_type    hold;
      logic        last;
   } ucode_word_type;

   typedef struct packed {
      op_type      op;
      mul_sel_type mul;
      logic        en;
   } dp_ctrl_type;

   typedef struct packed {
      logic [TEMP_W-1:0] setpoint;
      logic [GAIN_W-1:0] prop_gain;
      logic [GAIN_W-1:0] integ_gain;
   } csr_type;

   function automatic ucode_word_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_word_type w;
      case (step)
         4'd0: w = '{op: OP_LOAD,  mul: MUL_RECIP, hold: HOLD_IN,   last: 1'b0};
         4'd1: w = '{op: OP_MUL,   mul: MUL_RECIP, hold: HOLD_NONE, last: 1'b0};
         4'd2: w = '{op: OP_QUOT,  mul: MUL_RECIP, hold: HOLD_NONE, last: 1'b0};
         4'd3: w = '{op: OP_FIX,   mul: MUL_RECIP, hold: HOLD_NONE, last: 1'b0};
         4'd4: w = '{op: OP_ERR,   mul: MUL_RECIP, hold: HOLD_NONE, last: 1'b0};
         4'd5: w = '{op: OP_MUL,   mul: MUL_INTEG, hold: HOLD_NONE, last: 1'b0};
         4'd6: w = '{op: OP_INTEG, mul: MUL_INTEG, hold: HOLD_NONE, last: 1'b0};
         4'd7: w = '{op: OP_MUL,   mul: MUL_PROP,  hold: HOLD_NONE, last: 1'b0};
         4'd8: w = '{op: OP_DRIVE, mul: MUL_PROP,  hold: HOLD_OUT,  last: 1'b1};
         default: w = '{op: OP_LOAD, mul: MUL_RECIP, hold: HOLD_IN, last: 1'b0};
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/pi_temperature_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pi_temperature_controller
// PI controller with clamped integrator: one sensor sample in, one drive
// value, temperature and saturation flag out.
// ----------------------------------------------------------------------------
// Each accepted sample is converted to a temperature in degrees times 256,
// compared against the setpoint, and run through a PI law whose integrator
// and drive are both clamped to 0 .. 255.0. A nine-step microcode program
// drives one shared registered multiplier, used three times per item (for
// the reciprocal division of the sample, the integral term and the
// proportional term), so one item is processed at a time: the sample is
// taken at step zero, where the program waits for a request, and the result
// is registered at the last step. A finished result sits in the output
// register while the next sample is accepted; at its last step the program
// stalls only if the previous result is still not taken. Register writes
// are applied at once and should be made while no item is in flight.
// ----------------------------------------------------------------------------
module pi_temperature_controller #(
   parameter int unsigned ADC_BITS = pitc_pkg::ADC_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [pitc_pkg::SAMPLE_W-1:0]      req_adc_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [pitc_pkg::DRIVE_W-1:0]       rsp_drive,
   output logic [pitc_pkg::TEMP_W-1:0]        rsp_temperature,
   output logic                               rsp_drive_saturated,
   input  logic                               csr_write_en,
   input  logic [pitc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pitc_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import pitc_pkg::*;

   csr_type     csr_ff, csr_in;
   dp_ctrl_type ctrl;
   logic        out_busy;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_SETPOINT:   csr_in.setpoint   = TEMP_W'(csr_write_data);
            CSR_PROP_GAIN:  csr_in.prop_gain  = GAIN_W'(csr_write_data);
            CSR_INTEG_GAIN: csr_in.integ_gain = GAIN_W'(csr_write_data);
            default:        csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '{setpoint: SETPOINT_RST, prop_gain: PROP_GAIN_RST,
                     integ_gain: INTEG_GAIN_RST};
      end else begin
         csr_ff <= csr_in;
      end
   end

   pitc_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_busy  (out_busy),
      .req_ready (req_ready),
      .ctrl      (ctrl)
   );

   pitc_dp #(
      .ADC_BITS (ADC_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .ctrl                (ctrl),
      .csr                 (csr_ff),
      .req_adc_sample      (req_adc_sample),
      .rsp_ready           (rsp_ready),
      .out_busy            (out_busy),
      .rsp_valid           (rsp_valid),
      .rsp_drive           (rsp_drive),
      .rsp_temperature     (rsp_temperature),
      .rsp_drive_saturated (rsp_drive_saturated)
   );

endmodule
`default_nettype wire

@@ hw/rtl/pitc_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pitc_seq
// Step counter over the microcode program; holds on input or output waits
// and hands the current control word to the datapath.
// ----------------------------------------------------------------------------
module pitc_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  out_busy,
   output logic                  req_ready,
   output pitc_pkg::dp_ctrl_type ctrl
);
   import pitc_pkg::*;

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   ucode_word_type    word;
   logic              hold;

   always_comb begin
      word = ucode_rom(step_ff);
      case (word.hold)
         HOLD_IN:  hold = !req_valid;
         HOLD_OUT: hold = out_busy;
         default:  hold = 1'b0;
      endcase
      if (hold) begin
         step_in = step_ff;
      end else if (word.last) begin
         step_in = '0;
      end else begin
         step_in = step_ff + STEP_W'(1);
      end
   end

   always_comb begin
      ctrl      = '{op: word.op, mul: word.mul, en: !hold};
      req_ready = (word.op == OP_LOAD);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/pitc_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pitc_dp
// Datapath: sample scaling, reciprocal division, error, clamped integrator
// and drive, all around one shared registered multiplier.
// ----------------------------------------------------------------------------
module pitc_dp #(
   parameter int unsigned ADC_BITS = pitc_pkg::ADC_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  pitc_pkg::dp_ctrl_type              ctrl,
   input  pitc_pkg::csr_type                  csr,
   input  logic [pitc_pkg::SAMPLE_W-1:0]      req_adc_sample,
   input  logic                               rsp_ready,
   output logic                               out_busy,
   output logic                               rsp_valid,
   output logic [pitc_pkg::DRIVE_W-1:0]       rsp_drive,
   output logic [pitc_pkg::TEMP_W-1:0]        rsp_temperature,
   output logic                               rsp_drive_saturated
);
   import pitc_pkg::*;

   localparam int unsigned XW  = ADC_BITS + 17;
   localparam int unsigned AW  = XW + 1;
   localparam int unsigned PW  = AW + MB_W + 1;
   localparam int unsigned RSH = XW;
   localparam logic [ADC_BITS-1:0] DMAX  = '1;
   localparam logic [ADC_BITS-1:0] DHALF = DMAX >> 1;
   localparam logic [MB_W-1:0]     RECIP = MB_W'((64'd1 << RSH) / 64'(DMAX));

   logic [XW-1:0]              x_ff, x_in;
   logic signed [PW-1:0]       prod_ff, prod_in;
   logic [TEMP_W-1:0]          q_ff, q_in;
   logic [TEMP_W-1:0]          temp_ff, temp_in;
   logic signed [ERR_W-1:0]    err_ff, err_in;
   logic [INTEG_W-1:0]         integ_ff, integ_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [DRIVE_W-1:0]         rsp_drive_ff, rsp_drive_in;
   logic [TEMP_W-1:0]          rsp_temperature_ff, rsp_temperature_in;
   logic                       rsp_sat_ff, rsp_sat_in;

   logic [ADC_BITS-1:0]        samp;
   logic [ADC_BITS+6:0]        s125;
   logic signed [AW-1:0]       mul_a;
   logic signed [MB_W:0]       mul_b;
   logic [XW:0]                rem;
   logic signed [SUM_W-1:0]    twice;
   logic signed [SUM_W-1:0]    raw;

   // sample clamped to the ADC range, times 125 (times 128000 plus half divisor at load)
   always_comb begin
      if (32'(req_adc_sample) > 32'(DMAX)) begin
         samp = DMAX;
      end else begin
         samp = ADC_BITS'(req_adc_sample);
      end
      s125 = {samp, 7'b0} - (ADC_BITS+7)'({samp, 1'b0}) - (ADC_BITS+7)'(samp);
   end

   always_comb begin
      case (ctrl.mul)
         MUL_RECIP: begin
            mul_a = $signed({1'b0, x_ff});
            mul_b = $signed({1'b0, RECIP});
         end
         MUL_INTEG: begin
            mul_a = AW'(err_ff);
            mul_b = $signed({1'b0, MB_W'(csr.integ_gain)});
         end
         default: begin
            mul_a = AW'(err_ff);
            mul_b = $signed({1'b0, MB_W'(csr.prop_gain)});
         end
      endcase
   end

   // remainder of the reciprocal estimate, always below twice the divisor
   always_comb begin
      rem   = (XW+1)'(x_ff) + (XW+1)'(q_ff) - (XW+1)'({q_ff, {ADC_BITS{1'b0}}});
      twice = $signed(prod_ff[SUM_W-1:0]) + $signed(SUM_W'({integ_ff, 1'b0}));
      raw   = $signed(prod_ff[SUM_W-1:0]) + $signed(SUM_W'(integ_ff));
   end

   always_comb begin
      x_in               = x_ff;
      prod_in            = prod_ff;
      q_in               = q_ff;
      temp_in            = temp_ff;
      err_in             = err_ff;
      integ_in           = integ_ff;
      rsp_drive_in       = rsp_drive_ff;
      rsp_temperature_in = rsp_temperature_ff;
      rsp_sat_in         = rsp_sat_ff;
      rsp_valid_in       = rsp_ready ? 1'b0 : rsp_valid_ff;
      if (ctrl.en) begin
         case (ctrl.op)
            OP_LOAD: x_in = {s125, 10'b0} + XW'(DHALF);
            OP_MUL:  prod_in = mul_a * mul_b;
            OP_QUOT: q_in = prod_ff[RSH+TEMP_W-1:RSH];
            OP_FIX:  temp_in = q_ff + TEMP_W'(rem >= (XW+1)'(DMAX));
            OP_ERR:  err_in = $signed({1'b0, csr.setpoint}) - $signed({1'b0, temp_ff});
            OP_INTEG: begin
               if (twice[SUM_W-1]) begin
                  integ_in = '0;
               end else if (twice > $signed(SUM_W'(LIMIT_X2))) begin
                  integ_in = LIMIT_Q16;
               end else begin
                  integ_in = twice[INTEG_W:1];
               end
            end
            OP_DRIVE: begin
               rsp_valid_in       = 1'b1;
               rsp_temperature_in = temp_ff;
               if (raw[SUM_W-1]) begin
                  rsp_drive_in = '0;
                  rsp_sat_in   = 1'b1;
               end else if (raw > $signed(SUM_W'(LIMIT_Q16))) begin
                  rsp_drive_in = LIMIT_Q16[INTEG_W-1:16];
                  rsp_sat_in   = 1'b1;
               end else begin
                  rsp_drive_in = raw[INTEG_W-1:16];
                  rsp_sat_in   = 1'b0;
               end
            end
            default: x_in = x_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         integ_ff     <= integ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff               <= x_in;
      prod_ff            <= prod_in;
      q_ff               <= q_in;
      temp_ff            <= temp_in;
      err_ff             <= err_in;
      rsp_drive_ff       <= rsp_drive_in;
      rsp_temperature_ff <= rsp_temperature_in;
      rsp_sat_ff         <= rsp_sat_in;
   end

   assign out_busy            = rsp_valid_ff && !rsp_ready;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_drive           = rsp_drive_ff;
   assign rsp_temperature     = rsp_temperature_ff;
   assign rsp_drive_saturated = rsp_sat_ff;

endmodule
`default_nettype wire
